/* rtl/tdm_pkg.sv */
// ----------------------------------------------------------------------------
// tdm_pkg
// Types and constants shared by the tape deck mechanism emulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tdm_pkg;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_BYTE   = 2'd1,
		OP_ENABLE = 2'd2,
		OP_NONE   = 2'd3
	} tdm_op_t;

	typedef enum logic [2:0] {
		M_SETTLE   = 3'd0,
		M_WAITBTN  = 3'd1,
		M_INSERT   = 3'd2,
		M_IDLE_OUT = 3'd3,
		M_IDLE_IN  = 3'd4,
		M_START    = 3'd5,
		M_PLAY     = 3'd6
	} tdm_mode_t;

	// Step counter shared by the play sequence and the pulse generator.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_SETTLE     = 3'd0;
	localparam logic [2:0] REG_PLAY_LEAD  = 3'd1;
	localparam logic [2:0] REG_PLAY_LOW   = 3'd2;
	localparam logic [2:0] REG_PLAY_HIGH  = 3'd3;
	localparam logic [2:0] REG_PULSE_LOW  = 3'd4;
	localparam logic [2:0] REG_PULSE_HIGH = 3'd5;

	localparam logic [9:0] SETTLE_RESET     = 10'd200;
	localparam logic [9:0] PLAY_LEAD_RESET  = 10'd300;
	localparam logic [9:0] PLAY_LOW_RESET   = 10'd337;
	localparam logic [9:0] PLAY_HIGH_RESET  = 10'd77;
	localparam logic [7:0] PULSE_LOW_RESET  = 8'd1;
	localparam logic [7:0] PULSE_HIGH_RESET = 8'd25;

	localparam logic [7:0] CMD_PLAY_A = 8'hAC;
	localparam logic [7:0] CMD_PLAY_B = 8'hA8;
	localparam logic [7:0] CMD_STOP   = 8'h00;

	typedef struct packed {
		logic [9:0] settle_ticks;
		logic [9:0] play_lead_ticks;
		logic [9:0] play_low_ticks;
		logic [9:0] play_high_ticks;
		logic [7:0] pulse_low_ticks;
		logic [7:0] pulse_high_ticks;
	} tdm_cfg_t;

	typedef struct packed {
		tdm_op_t    op;
		logic [7:0] data_byte;
		logic       enable_n;
		logic       button_n;
	} tdm_item_t;

	typedef struct packed {
		tdm_mode_t  mode;
		logic [1:0] phase;
		logic [9:0] tick_count;
		logic       clock_busy;
		logic       select_level;
		logic       switch_reg;
		logic       pulse_active;
		logic       green;
		logic       red;
		logic       drive;
	} tdm_state_t;

endpackage

`default_nettype wire

/* rtl/tdm_cfg.sv */
// ----------------------------------------------------------------------------
// tdm_cfg
// Configuration register file: timing values for the mechanism emulator.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_cfg import tdm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [9:0] cfg_data,
	output tdm_cfg_t        cfg
);

	tdm_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks     <= SETTLE_RESET;
			cfg_q.play_lead_ticks  <= PLAY_LEAD_RESET;
			cfg_q.play_low_ticks   <= PLAY_LOW_RESET;
			cfg_q.play_high_ticks  <= PLAY_HIGH_RESET;
			cfg_q.pulse_low_ticks  <= PULSE_LOW_RESET;
			cfg_q.pulse_high_ticks <= PULSE_HIGH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETTLE:     cfg_q.settle_ticks     <= cfg_data;
				REG_PLAY_LEAD:  cfg_q.play_lead_ticks  <= cfg_data;
				REG_PLAY_LOW:   cfg_q.play_low_ticks   <= cfg_data;
				REG_PLAY_HIGH:  cfg_q.play_high_ticks  <= cfg_data;
				REG_PULSE_LOW:  cfg_q.pulse_low_ticks  <= cfg_data[7:0];
				REG_PULSE_HIGH: cfg_q.pulse_high_ticks <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/tdm_step.sv */
// ----------------------------------------------------------------------------
// tdm_step
// Next-state logic: applies one event item to the mechanism state.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_step import tdm_pkg::*; (
	input  wire tdm_state_t cur,
	input  wire tdm_item_t  item,
	input  wire tdm_cfg_t   cfg,
	output tdm_state_t      nxt
);

	// Mode handling on a tick. When adv is low the timed waits do not count;
	// this is the tick that just finished a clock pulse.
	function automatic tdm_state_t mode_tick(input tdm_state_t s, input logic adv,
			input logic btn, input tdm_cfg_t c);
		tdm_state_t r;
		logic [9:0] inc;
		r   = s;
		inc = s.tick_count + 10'd1;
		case (s.mode)
			M_SETTLE: begin
				r.switch_reg = 1'b0;
				if (adv) begin
					r.tick_count = inc;
					if (inc >= c.settle_ticks) begin
						r.mode       = M_WAITBTN;
						r.tick_count = '0;
					end
				end
			end
			M_WAITBTN: begin
				if (!btn) begin
					r.mode       = M_INSERT;
					r.switch_reg = 1'b1;
					r.tick_count = '0;
				end
			end
			M_INSERT: begin
				r.switch_reg = 1'b1;
				if (adv) begin
					r.tick_count = inc;
					if (inc >= c.settle_ticks) begin
						r.tick_count = '0;
						// A play command seen during startup is held in phase.
						if (s.phase == PH_SECOND) begin
							r.mode  = M_START;
							r.phase = PH_FIRST;
						end else begin
							r.mode       = M_IDLE_OUT;
							r.switch_reg = 1'b0;
							r.red        = 1'b1;
							r.green      = 1'b0;
						end
					end
				end
			end
			M_IDLE_OUT: begin
				r.red        = 1'b1;
				r.green      = 1'b0;
				r.switch_reg = 1'b0;
			end
			M_IDLE_IN: begin
				r.red        = 1'b0;
				r.green      = 1'b0;
				r.switch_reg = 1'b1;
			end
			M_START: begin
				if (s.phase == PH_FIRST) begin
					r.switch_reg = 1'b1;
					if (adv) begin
						r.tick_count = inc;
						if (inc >= c.play_lead_ticks) begin
							r.switch_reg = 1'b0;
							r.phase      = PH_SECOND;
							r.tick_count = '0;
						end
					end
				end else if (s.phase == PH_SECOND) begin
					r.switch_reg = 1'b0;
					if (adv) begin
						r.tick_count = inc;
						if (inc >= c.play_low_ticks) begin
							r.switch_reg = 1'b1;
							r.phase      = PH_THIRD;
							r.tick_count = '0;
						end
					end
				end else begin
					r.switch_reg = 1'b1;
					if (adv) begin
						r.tick_count = inc;
						if (inc >= c.play_high_ticks) begin
							r.switch_reg = 1'b0;
							r.phase      = PH_FIRST;
							r.tick_count = '0;
							r.mode       = M_PLAY;
						end
					end
				end
			end
			M_PLAY: begin
				if (!s.clock_busy) begin
					r.red          = 1'b0;
					r.green        = 1'b1;
					r.pulse_active = 1'b1;
					r.drive        = 1'b1;
					r.phase        = PH_FIRST;
					r.tick_count   = '0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	logic [9:0] inc;
	logic       is_play;

	assign inc     = cur.tick_count + 10'd1;
	assign is_play = (item.data_byte == CMD_PLAY_A) || (item.data_byte == CMD_PLAY_B);

	always_comb begin
		nxt = cur;
		case (item.op)
			OP_TICK: begin
				if (cur.pulse_active) begin
					nxt.tick_count = inc;
					if (cur.phase == PH_FIRST) begin
						if (inc >= {2'b00, cfg.pulse_low_ticks}) begin
							nxt.drive      = 1'b0;
							nxt.phase      = PH_SECOND;
							nxt.tick_count = '0;
						end
					end else if (inc >= {2'b00, cfg.pulse_high_ticks}) begin
						nxt.pulse_active = 1'b0;
						nxt.phase        = PH_FIRST;
						nxt.tick_count   = '0;
						nxt = mode_tick(nxt, 1'b0, item.button_n, cfg);
					end
				end else begin
					nxt = mode_tick(cur, 1'b1, item.button_n, cfg);
				end
			end
			OP_BYTE: begin
				if (is_play) begin
					if (cur.mode == M_SETTLE || cur.mode == M_WAITBTN ||
							cur.mode == M_INSERT) begin
						nxt.phase = PH_SECOND;
					end else if (cur.mode == M_IDLE_OUT || cur.mode == M_IDLE_IN ||
							cur.mode == M_PLAY) begin
						nxt.mode = M_START;
						// A running pulse keeps its own timing until it ends.
						if (!cur.pulse_active) begin
							nxt.phase      = PH_FIRST;
							nxt.tick_count = '0;
						end
					end
				end else if (item.data_byte == CMD_STOP && cur.mode == M_PLAY) begin
					nxt.mode = M_IDLE_IN;
				end
			end
			OP_ENABLE: begin
				if (item.enable_n) begin
					nxt.select_level = 1'b1;
					nxt.clock_busy   = 1'b0;
				end else begin
					nxt.select_level = 1'b0;
					nxt.clock_busy   = 1'b1;
					nxt.drive        = 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/tape_deck_mechanism_emulator.sv */
// ----------------------------------------------------------------------------
// tape_deck_mechanism_emulator
// Cassette mechanism emulator: turns tick, command byte and enable events
// into switch, clock, select and LED levels.
//
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     op, data_byte, enable_n, button_n
// result    out        out_valid / out_stall   switch_level, clock_drive_low,
//                                              select_out_n, led_red, led_run,
//                                              mode
// config    in         cfg_we                  cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; its result becomes valid
// when the item moves from the input register into the result register.
// The mechanism state is updated on that same move, so items are applied
// strictly in order.
// A stalled result holds the result register and, once the input register is
// also full, in_stall rises. Reset restores the default timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_deck_mechanism_emulator import tdm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] op,
	input  wire logic [7:0] data_byte,
	input  wire logic       enable_n,
	input  wire logic       button_n,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            switch_level,
	output logic            clock_drive_low,
	output logic            select_out_n,
	output logic            led_red,
	output logic            led_run,
	output logic [2:0]      mode,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [9:0] cfg_data
);

	tdm_cfg_t   cfg;
	tdm_state_t state_q;
	tdm_state_t state_next;
	tdm_item_t  item_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic       advance;
	logic       in_take;
	tdm_state_t result_q;

	tdm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tdm_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg),
		.nxt  (state_next)
	);

	// The result register is free when empty or being taken this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op        <= tdm_op_t'(op);
			item_s1.data_byte <= data_byte;
			item_s1.enable_n  <= enable_n;
			item_s1.button_n  <= button_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= M_SETTLE;
			state_q.phase        <= PH_FIRST;
			state_q.tick_count   <= '0;
			state_q.clock_busy   <= 1'b0;
			state_q.select_level <= 1'b1;
			state_q.switch_reg   <= 1'b0;
			state_q.pulse_active <= 1'b0;
			state_q.green        <= 1'b0;
			state_q.red          <= 1'b1;
			state_q.drive        <= 1'b0;
			out_valid_q          <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= state_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign switch_level    = result_q.switch_reg;
	assign clock_drive_low = result_q.drive;
	assign select_out_n    = result_q.select_level;
	assign led_red         = result_q.red;
	assign led_run         = result_q.green;
	assign mode            = result_q.mode;

endmodule

`default_nettype wire
